// ===== design/fpa_pkg.sv =====
`default_nettype none

package fpa_pkg;

    localparam int DataW    = 32;
    localparam int FuncW    = 4;
    localparam int DivSteps = DataW;

    // Operation codes carried on the input tuser
    typedef enum logic [FuncW-1:0] {
        FN_ADD      = 4'd0,
        FN_SUB      = 4'd1,
        FN_MUL      = 4'd2,
        FN_DIV      = 4'd3,
        FN_GT       = 4'd4,
        FN_LT       = 4'd5,
        FN_GE       = 4'd6,
        FN_LE       = 4'd7,
        FN_EQ       = 4'd8,
        FN_NE       = 4'd9,
        FN_INC      = 4'd10,
        FN_DEC      = 4'd11,
        FN_MIN      = 4'd12,
        FN_MAX      = 4'd13,
        FN_TO_INT   = 4'd14,
        FN_FROM_INT = 4'd15
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    localparam logic [DataW-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DataW-1:0] SAT_NEG = 32'h8000_0000;

    // Per-item control that rides along the whole pipeline
    typedef struct packed {
        t_func            func;
        logic [DataW-1:0] res;   // result of the operations computed in the input stage
        logic             cmp;
        t_status          st;
        logic             neg;   // sign of a product or quotient
        logic             div0;
        logic             dovf;  // quotient does not fit in 32 bits
    } t_ctl;

    // Operand magnitudes and divider state
    typedef struct packed {
        logic [DataW-1:0] mag_a;
        logic [DataW-1:0] mag_b;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] quo;
    } t_div;

    // Rounded magnitude of a product or quotient
    typedef struct packed {
        logic [DataW-1:0] mag;
        logic             big;   // magnitude at or above 2^32
    } t_mag;

endpackage

`default_nettype wire

// ===== design/fpa_front.sv =====
`default_nettype none

module fpa_front #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire fpa_pkg::t_func i_func,
    input  wire logic [31:0]   i_a,
    input  wire logic [31:0]   i_b,
    output logic               o_valid,
    input  wire logic          i_ready,
    output fpa_pkg::t_ctl      o_ctl,
    output fpa_pkg::t_div      o_div
);
    import fpa_pkg::*;

    logic             r_valid;
    t_ctl             r_ctl;
    t_div             r_div;
    t_ctl             n_ctl;
    t_div             n_div;

    logic [DataW:0]   w_ax;
    logic [DataW:0]   w_yx;
    logic [DataW:0]   w_sum;
    logic             w_add_sat;
    logic             w_lt;
    logic             w_eq;
    logic             w_gt;
    logic [DataW-1:0] w_shr;
    logic [DataW-1:0] w_shl;
    logic [DataW-1:0] w_hi;
    logic             w_fits;
    logic [DataW-1:0] w_mag_a;
    logic [DataW-1:0] w_mag_b;
    logic [DataW-1:0] w_p0;

    // Shared 33-bit adder for add, sub, inc and dec
    always_comb begin
        w_ax = {i_a[DataW-1], i_a};
        unique case (i_func)
            FN_SUB:  w_yx = (DataW+1)'(-{i_b[DataW-1], i_b});
            FN_INC:  w_yx = (DataW+1)'(1);
            FN_DEC:  w_yx = '1;
            default: w_yx = {i_b[DataW-1], i_b};
        endcase
        w_sum     = w_ax + w_yx;
        w_add_sat = w_sum[DataW] != w_sum[DataW-1];
    end

    // Compare, shift and magnitude logic
    always_comb begin
        w_lt    = $signed(i_a) < $signed(i_b);
        w_eq    = i_a == i_b;
        w_gt    = !w_lt && !w_eq;
        w_shr   = DataW'($signed(i_a) >>> FRAC_BITS);
        w_shl   = DataW'(i_a << FRAC_BITS);
        w_hi    = DataW'($signed(i_a) >>> (DataW - 1 - FRAC_BITS));
        w_fits  = (w_hi == '0) || (w_hi == '1);
        w_mag_a = i_a[DataW-1] ? DataW'(-i_a) : i_a;
        w_mag_b = i_b[DataW-1] ? DataW'(-i_b) : i_b;
        // Upper bits of the shifted dividend seed the partial remainder
        w_p0    = w_mag_a >> (DataW - FRAC_BITS);
    end

    // Build the item control word
    always_comb begin
        n_ctl.func = i_func;
        n_ctl.res  = '0;
        n_ctl.cmp  = 1'b0;
        n_ctl.st   = ST_OK;
        n_ctl.neg  = i_a[DataW-1] ^ i_b[DataW-1];
        n_ctl.div0 = i_b == '0;
        n_ctl.dovf = w_p0 >= w_mag_b;
        unique case (i_func)
            FN_ADD, FN_SUB, FN_INC, FN_DEC: begin
                if (w_add_sat) begin
                    n_ctl.res = w_sum[DataW] ? SAT_NEG : SAT_POS;
                    n_ctl.st  = ST_SAT;
                end else begin
                    n_ctl.res = w_sum[DataW-1:0];
                end
            end
            FN_MUL, FN_DIV: n_ctl.res = '0;
            FN_GT:          n_ctl.cmp = w_gt;
            FN_LT:          n_ctl.cmp = w_lt;
            FN_GE:          n_ctl.cmp = !w_lt;
            FN_LE:          n_ctl.cmp = w_lt || w_eq;
            FN_EQ:          n_ctl.cmp = w_eq;
            FN_NE:          n_ctl.cmp = !w_eq;
            FN_MIN:         n_ctl.res = w_lt ? i_a : i_b;
            FN_MAX:         n_ctl.res = w_gt ? i_a : i_b;
            FN_TO_INT:      n_ctl.res = w_shr;
            FN_FROM_INT: begin
                if (w_fits) begin
                    n_ctl.res = w_shl;
                end else begin
                    n_ctl.res = i_a[DataW-1] ? SAT_NEG : SAT_POS;
                    n_ctl.st  = ST_SAT;
                end
            end
        endcase
        n_div.mag_a = w_mag_a;
        n_div.mag_b = w_mag_b;
        n_div.rem   = w_p0;
        n_div.quo   = '0;
    end

    // Advance when this stage is empty or the next one takes its item
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ctl <= n_ctl;
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_div   = r_div;

endmodule

`default_nettype wire

// ===== design/fpa_div_step.sv =====
`default_nettype none

module fpa_div_step #(
    parameter int FRAC_BITS = 8,
    parameter int STEP      = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire fpa_pkg::t_ctl i_ctl,
    input  wire fpa_pkg::t_div i_div,
    output logic               o_valid,
    input  wire logic          i_ready,
    output fpa_pkg::t_ctl      o_ctl,
    output fpa_pkg::t_div      o_div
);
    import fpa_pkg::*;

    // Quotient bit produced by this stage, most significant first
    localparam int QBit = DataW - 1 - STEP;

    logic             r_valid;
    t_ctl             r_ctl;
    t_div             r_div;
    t_div             n_div;
    logic             w_nbit;
    logic [DataW:0]   w_trial;
    logic [DataW+1:0] w_diff;
    logic             w_take;

    // Next dividend bit: the dividend is mag_a shifted left by FRAC_BITS
    if (QBit >= FRAC_BITS) begin : g_dbit
        assign w_nbit = i_div.mag_a[QBit-FRAC_BITS];
    end else begin : g_zbit
        assign w_nbit = 1'b0;
    end

    // One restoring division step
    always_comb begin
        w_trial = {i_div.rem, w_nbit};
        w_diff  = {1'b0, w_trial} - {2'b00, i_div.mag_b};
        w_take  = !w_diff[DataW+1];
        n_div   = i_div;
        n_div.rem = w_take ? w_diff[DataW-1:0] : w_trial[DataW-1:0];
        n_div.quo[QBit] = w_take;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ctl <= i_ctl;
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_div   = r_div;

endmodule

`default_nettype wire

// ===== design/fpa_mul.sv =====
`default_nettype none

module fpa_mul (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire fpa_pkg::t_ctl i_ctl,
    input  wire fpa_pkg::t_div i_div,
    output logic               o_valid,
    input  wire logic          i_ready,
    output fpa_pkg::t_ctl      o_ctl,
    output fpa_pkg::t_div      o_div,
    output logic [63:0]        o_prod
);
    import fpa_pkg::*;

    logic               r_valid;
    t_ctl               r_ctl;
    t_div               r_div;
    logic [2*DataW-1:0] r_prod;
    logic [2*DataW-1:0] n_prod;

    // Unsigned 32x32 magnitude product
    assign n_prod  = (2*DataW)'(i_div.mag_a) * (2*DataW)'(i_div.mag_b);

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ctl  <= i_ctl;
            r_div  <= i_div;
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_div   = r_div;
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

// ===== design/fpa_round.sv =====
`default_nettype none

module fpa_round #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire fpa_pkg::t_ctl i_ctl,
    input  wire fpa_pkg::t_div i_div,
    input  wire logic [63:0]   i_prod,
    output logic               o_valid,
    input  wire logic          i_ready,
    output fpa_pkg::t_ctl      o_ctl,
    output fpa_pkg::t_mag      o_mag
);
    import fpa_pkg::*;

    localparam logic [2*DataW-1:0] Half = (2*DataW)'(1) << (FRAC_BITS - 1);

    logic               r_valid;
    t_ctl               r_ctl;
    t_mag               r_mag;
    t_mag               n_mag;
    logic [2*DataW-1:0] w_msum;
    logic [2*DataW-1:0] w_mq;
    logic               w_up;
    logic [DataW:0]     w_q1;

    // Round product and quotient half away from zero on magnitudes
    always_comb begin
        w_msum = i_prod + Half;
        w_mq   = w_msum >> FRAC_BITS;
        w_up   = {i_div.rem, 1'b0} >= {1'b0, i_div.mag_b};
        w_q1   = {1'b0, i_div.quo} + (DataW+1)'(w_up);
        if (i_ctl.func == FN_DIV) begin
            n_mag.mag = w_q1[DataW-1:0];
            n_mag.big = i_ctl.dovf || w_q1[DataW];
        end else begin
            n_mag.mag = w_mq[DataW-1:0];
            n_mag.big = |w_mq[2*DataW-1:DataW];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ctl <= i_ctl;
            r_mag <= n_mag;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_mag   = r_mag;

endmodule

`default_nettype wire

// ===== design/fpa_final.sv =====
`default_nettype none

module fpa_final (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire fpa_pkg::t_ctl i_ctl,
    input  wire fpa_pkg::t_mag i_mag,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [31:0]        o_res,
    output logic               o_cmp,
    output fpa_pkg::t_status   o_st
);
    import fpa_pkg::*;

    logic             r_valid;
    logic [DataW-1:0] r_res;
    logic             r_cmp;
    t_status          r_st;
    logic [DataW-1:0] n_res;
    t_status          n_st;
    logic             w_sat;
    logic [DataW-1:0] w_val;

    // Apply sign, saturate and pick the result source
    always_comb begin
        if (i_ctl.neg) begin
            w_sat = i_mag.big || (i_mag.mag > SAT_NEG);
            w_val = DataW'(-i_mag.mag);
        end else begin
            w_sat = i_mag.big || i_mag.mag[DataW-1];
            w_val = i_mag.mag;
        end
        n_res = i_ctl.res;
        n_st  = i_ctl.st;
        if (i_ctl.func == FN_MUL || i_ctl.func == FN_DIV) begin
            priority if (i_ctl.func == FN_DIV && i_ctl.div0) begin
                n_res = '0;
                n_st  = ST_DIV0;
            end else if (w_sat) begin
                n_res = i_ctl.neg ? SAT_NEG : SAT_POS;
                n_st  = ST_SAT;
            end else begin
                n_res = w_val;
                n_st  = ST_OK;
            end
        end
    end

    // Output register: hold while the receiver stalls
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= n_res;
            r_cmp <= i_ctl.cmp;
            r_st  <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_cmp   = r_cmp;
    assign o_st    = r_st;

endmodule

`default_nettype wire

// ===== design/fixed_point_alu_core.sv =====
// Signed 32-bit fixed-point ALU, FRAC_BITS fractional bits (Q24.8 by default).
// Input stream: i_s_tdata carries operand_a (bits 31:0) and operand_b
// (bits 63:32); i_s_tuser[3:0] carries the operation code. Output stream:
// o_m_tdata is the raw result, o_m_tuser[0] the comparison flag and
// o_m_tuser[2:1] the status (ok, saturated, division by zero).
// Every operation goes through the same 36-stage pipeline: one input stage,
// 32 restoring divider stages (one quotient bit each), a multiplier stage,
// a rounding stage and an output register. A new item can be accepted every
// cycle unless an output stall has filled every stage. The 32x32 multiplier
// stage and the ready path, which runs combinationally back through every
// stage, set the cycle time.
// Each stage holds a valid bit and takes a new item when it is empty or its
// successor takes its item, so bubbles close up and items are accepted while
// the output holds a result the receiver has not yet taken. A stall holds
// every full stage with no empty stage after it; nothing is lost or repeated.
// Reset clears all valid bits; the block is ready in the first cycle after
// reset is released. Results leave in input order.
`default_nettype none

module fixed_point_alu_core #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [63:0]   i_s_tdata,   // operand_a[31:0], operand_b[63:32]
    input  wire logic [3:0]    i_s_tuser,   // func[3:0]
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [31:0]        o_m_tdata,   // result_value[31:0]
    output logic [2:0]         o_m_tuser    // compare_true[0], status[2:1]
);
    import fpa_pkg::*;

    logic    w_valid [0:DivSteps];
    logic    w_ready [0:DivSteps];
    t_ctl    w_ctl   [0:DivSteps];
    t_div    w_div   [0:DivSteps];

    logic               w_mul_valid;
    logic               w_mul_ready;
    t_ctl               w_mul_ctl;
    t_div               w_mul_div;
    logic [2*DataW-1:0] w_prod;

    logic    w_rnd_valid;
    logic    w_rnd_ready;
    t_ctl    w_rnd_ctl;
    t_mag    w_rnd_mag;

    logic [DataW-1:0] w_res;
    logic             w_cmp;
    t_status          w_st;

    // Decode, operations computed in the input stage, and divider setup
    fpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_func  (t_func'(i_s_tuser)),
        .i_a     (i_s_tdata[31:0]),
        .i_b     (i_s_tdata[63:32]),
        .o_valid (w_valid[0]),
        .i_ready (w_ready[0]),
        .o_ctl   (w_ctl[0]),
        .o_div   (w_div[0])
    );

    // Divider: one quotient bit per stage
    for (genvar k = 0; k < DivSteps; k++) begin : g_div
        fpa_div_step #(
            .FRAC_BITS (FRAC_BITS),
            .STEP      (k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_ctl   (w_ctl[k]),
            .i_div   (w_div[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_ctl   (w_ctl[k+1]),
            .o_div   (w_div[k+1])
        );
    end

    fpa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[DivSteps]),
        .o_ready (w_ready[DivSteps]),
        .i_ctl   (w_ctl[DivSteps]),
        .i_div   (w_div[DivSteps]),
        .o_valid (w_mul_valid),
        .i_ready (w_mul_ready),
        .o_ctl   (w_mul_ctl),
        .o_div   (w_mul_div),
        .o_prod  (w_prod)
    );

    fpa_round #(
        .FRAC_BITS (FRAC_BITS)
    ) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_valid),
        .o_ready (w_mul_ready),
        .i_ctl   (w_mul_ctl),
        .i_div   (w_mul_div),
        .i_prod  (w_prod),
        .o_valid (w_rnd_valid),
        .i_ready (w_rnd_ready),
        .o_ctl   (w_rnd_ctl),
        .o_mag   (w_rnd_mag)
    );

    fpa_final u_final (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_rnd_valid),
        .o_ready (w_rnd_ready),
        .i_ctl   (w_rnd_ctl),
        .i_mag   (w_rnd_mag),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (w_res),
        .o_cmp   (w_cmp),
        .o_st    (w_st)
    );

    assign o_m_tdata = w_res;
    assign o_m_tuser = {w_st, w_cmp};

    // Division by zero always returns a zero result
    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2:1] == ST_DIV0 |-> o_m_tdata == '0)
        else $error("division by zero with nonzero result");

    // A true comparison carries a zero result and ok status
    a_cmp_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == '0 && o_m_tuser[2:1] == ST_OK)
        else $error("comparison flag with result or status set");

    // A saturated result sits at one end of the range
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2:1] == ST_SAT |->
            o_m_tdata == SAT_POS || o_m_tdata == SAT_NEG)
        else $error("saturated result off the range limits");

    // An empty input stage always takes an item
    a_front_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_valid[0] |-> o_s_tready)
        else $error("input stalled with empty input stage");

endmodule

`default_nettype wire

// ===== tb/fpa_result_checker.sv =====
`timescale 1ns / 100ps

module fpa_result_checker #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [63:0] i_s_tdata,   // operand_a[31:0], operand_b[63:32]
    input  wire logic [3:0]  i_s_tuser,   // func[3:0]
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,   // result_value[31:0]
    input  wire logic [2:0]  i_m_tuser,   // compare_true[0], status[2:1]
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count,
    output int               o_sat_count,
    output int               o_div0_count
);
    import fpa_pkg::*;

    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam int     REPORT_LIMIT = 10;

    typedef struct packed {
        logic [31:0] value;
        logic        cmp;
        t_status     st;
    } alu_result_t;

    // Operation and operands kept beside the prediction for error reports
    typedef struct packed {
        t_func       fn;
        logic [31:0] a;
        logic [31:0] b;
        alu_result_t res;
    } alu_expect_t;

    alu_expect_t expected_results[$];
    alu_expect_t head;
    alu_result_t got;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
        o_sat_count    = 0;
        o_div0_count   = 0;
    end

    // Clamp a wide value into the signed 32-bit range
    function automatic logic [31:0] saturate32(input longint v, inout t_status st);
        if (v > I32_MAX) begin
            st = ST_SAT;
            return I32_MAX[31:0];
        end
        if (v < I32_MIN) begin
            st = ST_SAT;
            return I32_MIN[31:0];
        end
        return v[31:0];
    endfunction

    // Rebuild a signed value from sign and magnitude, saturating
    function automatic logic [31:0] from_magnitude(input logic neg, input longint unsigned mag,
                                                   inout t_status st);
        longint v;
        if (mag > 64'h8000_0001)
            mag = 64'h8000_0001;
        v = longint'(mag);
        return saturate32(neg ? -v : v, st);
    endfunction

    function automatic alu_result_t alu_predict(input t_func fn, input logic [31:0] a_raw,
                                                input logic [31:0] b_raw);
        longint          a;
        longint          b;
        longint unsigned mag_a;
        longint unsigned mag_b;
        longint unsigned wide;
        logic            neg;
        alu_result_t     r;
        a       = $signed(a_raw);
        b       = $signed(b_raw);
        mag_a   = (a < 0) ? -a : a;
        mag_b   = (b < 0) ? -b : b;
        neg     = (a < 0) != (b < 0);
        r.value = '0;
        r.cmp   = 1'b0;
        r.st    = ST_OK;
        case (fn)
            FN_ADD: r.value = saturate32(a + b, r.st);
            FN_SUB: r.value = saturate32(a - b, r.st);
            FN_MUL: begin
                // Round half away from zero on the magnitude
                wide    = mag_a * mag_b;
                wide    = (wide + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                r.value = from_magnitude(neg, wide, r.st);
            end
            FN_DIV: begin
                if (b == 0) begin
                    r.st = ST_DIV0;
                end else begin
                    wide    = mag_a << FRAC_BITS;
                    wide    = (2 * wide + mag_b) / (2 * mag_b);
                    r.value = from_magnitude(neg, wide, r.st);
                end
            end
            FN_GT:       r.cmp = a > b;
            FN_LT:       r.cmp = a < b;
            FN_GE:       r.cmp = a >= b;
            FN_LE:       r.cmp = a <= b;
            FN_EQ:       r.cmp = a == b;
            FN_NE:       r.cmp = a != b;
            FN_INC:      r.value = saturate32(a + 1, r.st);
            FN_DEC:      r.value = saturate32(a - 1, r.st);
            FN_MIN:      r.value = (a < b) ? a_raw : b_raw;
            FN_MAX:      r.value = (a > b) ? a_raw : b_raw;
            FN_TO_INT:   r.value = 32'(a >>> FRAC_BITS);
            FN_FROM_INT: r.value = saturate32(a <<< FRAC_BITS, r.st);
            default:     r.value = '0;
        endcase
        return r;
    endfunction

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= REPORT_LIMIT)
            $display("[%0t] mismatch %0d: %s", $time, o_fail_count, msg);
    endtask

    // Predict on every accepted input item, compare every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                head.fn  = t_func'(i_s_tuser);
                head.a   = i_s_tdata[31:0];
                head.b   = i_s_tdata[63:32];
                head.res = alu_predict(head.fn, head.a, head.b);
                expected_results.push_back(head);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.value = i_m_tdata;
                got.cmp   = i_m_tuser[0];
                got.st    = t_status'(i_m_tuser[2:1]);
                o_result_count++;
                if (got.st == ST_SAT)
                    o_sat_count++;
                if (got.st == ST_DIV0)
                    o_div0_count++;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected result value %h cmp %b status %0d",
                                           got.value, got.cmp, got.st));
                end else begin
                    head = expected_results.pop_front();
                    if (got.value !== head.res.value || got.cmp !== head.res.cmp ||
                        got.st !== head.res.st)
                        note_failure($sformatf(
                            "func %0d a %h b %h: expected %h/%b/%0d, got %h/%b/%0d",
                            head.fn, head.a, head.b, head.res.value, head.res.cmp,
                            head.res.st, got.value, got.cmp, got.st));
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ===== tb/fixed_point_alu_core_tb.sv =====
`timescale 1ns / 100ps

module fixed_point_alu_core_tb;
    import fpa_pkg::*;

    localparam int FRAC_BITS     = 8;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int CALM_ITEMS    = 350;   // final stretch without idling
    localparam int HOLD_AT_ITEM  = 300;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 50;
    localparam int CYCLE_LIMIT   = 200000;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [63:0] s_tdata    = '0;
    logic [3:0]  s_tuser    = '0;
    logic        m_tready   = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;
    wire  [2:0]  m_tuser;

    bit src_idle_en   = 1'b1;
    bit sink_idle_en  = 1'b1;
    bit hold_off_req  = 1'b0;
    int sent_count    = 0;
    int directed_count;
    int cycle_count;

    int fail_count;
    int pending;
    int result_count;
    int sat_count;
    int div0_count;

    fixed_point_alu_core #(
        .FRAC_BITS (FRAC_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    fpa_result_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_sat_count    (sat_count),
        .o_div0_count   (div0_count)
    );

    always #10 i_clk = ~i_clk;

    // Offer one item, with an optional idle burst first, and wait for acceptance
    task automatic send_item(input t_func fn, input logic [31:0] a, input logic [31:0] b);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tuser  <= fn;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent_count++;
    endtask

    // Mix of full-range, small, extreme, near-power-of-two and random-width operands
    function automatic logic [31:0] pick_operand();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 4095) - 32'd2048;
            2: begin
                case ($urandom_range(0, 6))
                    0:       v = SAT_POS;
                    1:       v = SAT_NEG;
                    2:       v = '0;
                    3:       v = 32'd1;
                    4:       v = '1;
                    5:       v = SAT_POS - 1;
                    default: v = SAT_NEG + 1;
                endcase
            end
            3: begin
                v = (32'h100 << $urandom_range(0, 8)) + $urandom_range(0, 3) - 32'd1;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: begin
                v = $urandom >> $urandom_range(1, 31);
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // Drive the receiver: random stalls, one long hold-off on request
    initial begin
        wait (i_rst_n);
        forever begin
            if (hold_off_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Abort a run that hangs
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
        $display("FAILURE");
        $finish;
    end

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        int          pick;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: saturation at both ends, rounding, divide by zero, every op
        send_item(FN_ADD, SAT_POS, 32'd1);
        send_item(FN_ADD, SAT_NEG, SAT_NEG);
        send_item(FN_SUB, SAT_NEG, 32'd1);
        send_item(FN_SUB, SAT_POS, 32'hFFFF_FFFF);
        send_item(FN_MUL, 32'h0000_0180, 32'h0000_0280);
        send_item(FN_MUL, 32'h0000_0001, 32'h0000_0080);
        send_item(FN_MUL, 32'hFFFF_FFFF, 32'h0000_0080);
        send_item(FN_MUL, SAT_NEG, SAT_NEG);
        send_item(FN_MUL, SAT_POS, 32'hFFFF_FF00);
        send_item(FN_DIV, 32'h0000_0100, 32'h0000_0000);
        send_item(FN_DIV, 32'h0000_0100, 32'h0000_0300);
        send_item(FN_DIV, SAT_NEG, 32'hFFFF_FFFF);
        send_item(FN_DIV, 32'hFFFF_FF80, 32'h0000_0300);
        send_item(FN_GT, SAT_POS, SAT_NEG);
        send_item(FN_LT, SAT_POS, SAT_NEG);
        send_item(FN_GE, 32'd5, 32'd5);
        send_item(FN_LE, SAT_NEG, SAT_NEG);
        send_item(FN_EQ, 32'd7, 32'd7);
        send_item(FN_NE, 32'd0, 32'd1);
        send_item(FN_INC, SAT_POS, 32'd0);
        send_item(FN_DEC, SAT_NEG, 32'd0);
        send_item(FN_MIN, 32'd3, 32'd3);
        send_item(FN_MAX, SAT_NEG, SAT_POS);
        send_item(FN_TO_INT, 32'hFFFF_FFFF, 32'd0);
        send_item(FN_TO_INT, SAT_NEG, 32'd0);
        send_item(FN_FROM_INT, 32'h0080_0000, 32'd0);
        send_item(FN_FROM_INT, 32'hFF80_0000, 32'd0);
        send_item(FN_FROM_INT, 32'hFFFF_FFFF, 32'd0);
        directed_count = sent_count;

        // Random operations; zero and equal divisors show up often
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == HOLD_AT_ITEM)
                hold_off_req = 1'b1;
            if (i == RANDOM_ITEMS - CALM_ITEMS) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            a    = pick_operand();
            pick = $urandom_range(0, 7);
            if (pick == 0)
                b = '0;
            else if (pick == 1)
                b = a;
            else
                b = pick_operand();
            send_item(t_func'($urandom_range(0, 15)), a, b);
        end
        s_tvalid <= 1'b0;

        // Drain the pipeline, then allow time for stray results
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d operations (%0d directed) over all 16 opcodes, with idle bursts",
                 sent_count, directed_count);
        $display("and a %0d-cycle output hold-off; %0d results checked, %0d saturated, %0d div0.",
                 HOLD_CYCLES, result_count, sat_count, div0_count);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/fpa_pkg.sv
design/fpa_front.sv
design/fpa_div_step.sv
design/fpa_mul.sv
design/fpa_round.sv
design/fpa_final.sv
design/fixed_point_alu_core.sv
tb/fpa_result_checker.sv
tb/fixed_point_alu_core_tb.sv
